// ----- hw/rtl/tskl_pkg.sv -----
`timescale 1ns / 1ps
package tskl_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [4:0] HOURS_PER_DAY    = 5'd24;
  localparam logic [5:0] MINUTES_PER_HOUR = 6'd60;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_CHANGE = 2'd2,
    OP_LIST   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_BAD_TIME  = 3'd4,
    ST_ENTRY     = 3'd5,
    ST_EMPTY     = 3'd6
  } status_t;

  // Per-cell update: keep, take the new entry, take a neighbour, or retime.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_FROM_LO,
    CELL_FROM_HI,
    CELL_SET_TIME
  } cell_op_t;

  typedef struct packed {
    logic [63:0] name;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic        kind;
    logic [63:0] payload;
  } entry_t;

  typedef struct packed {
    logic match;  // stored key equals the request key
    logic later;  // stored time is strictly later than the request time
  } cell_flag_t;

endpackage

// ----- hw/rtl/tskl_req_if.sv -----
`timescale 1ns / 1ps
interface tskl_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] name_tag;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic        place_kind;
  logic [63:0] payload;

  modport source (
    output valid, kind, name_tag, hour, minute, place_kind, payload,
    input  ready
  );
  modport sink (
    input  valid, kind, name_tag, hour, minute, place_kind, payload,
    output ready
  );
endinterface

// ----- hw/rtl/tskl_rsp_if.sv -----
`timescale 1ns / 1ps
interface tskl_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] entry_name;
  logic [4:0]  entry_hour;
  logic [5:0]  entry_minute;
  logic        entry_kind;
  logic [63:0] entry_payload;
  logic        last;

  modport source (
    output valid, status, entry_name, entry_hour, entry_minute, entry_kind,
           entry_payload, last,
    input  ready
  );
  modport sink (
    input  valid, status, entry_name, entry_hour, entry_minute, entry_kind,
           entry_payload, last,
    output ready
  );
endinterface

// ----- hw/rtl/tskl_cell.sv -----
`timescale 1ns / 1ps
module tskl_cell (
  input  logic                 clk,
  input  tskl_pkg::cell_op_t   op,
  input  tskl_pkg::entry_t     new_entry,
  input  tskl_pkg::entry_t     lo_entry,
  input  tskl_pkg::entry_t     hi_entry,
  output tskl_pkg::entry_t     entry,
  output tskl_pkg::cell_flag_t flag
);
  import tskl_pkg::*;

  entry_t slot;

  assign entry = slot;

  always_comb begin
    flag.match = (slot.name == new_entry.name);
    flag.later = (new_entry.hour < slot.hour) ||
                 ((new_entry.hour == slot.hour) && (new_entry.minute < slot.minute));
  end

  always_ff @(posedge clk) begin
    case (op)
      CELL_LOAD:     slot <= new_entry;
      CELL_FROM_LO:  slot <= lo_entry;
      CELL_FROM_HI:  slot <= hi_entry;
      CELL_SET_TIME: begin
        slot.hour   <= new_entry.hour;
        slot.minute <= new_entry.minute;
      end
      default:       slot <= slot;
    endcase
  end

endmodule

// ----- hw/rtl/time_sorted_keyed_list.sv -----
`timescale 1ns / 1ps
// Insert, delete and change give their one result, registered, in the cycle after the request.
// One update request per cycle while the result stage can be refilled; every cell compares and shifts at once.
// A list request walks the slot row (one entry per cycle while the receiver takes
// results, through the single read port) and holds off further requests until it ends.
// Reset (synchronous, active high) empties the list; slot contents stay undefined.
module time_sorted_keyed_list (
  input  logic      clk,
  input  logic      rst,
  tskl_req_if.sink  req,
  tskl_rsp_if.source rsp
);
  import tskl_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   fill_count;
  logic [IDX_W-1:0]   list_idx;

  // Registered result stage.
  logic               rsp_valid;
  status_t            rsp_status;
  entry_t             rsp_entry;
  logic               rsp_last;

  entry_t             slot   [CAPACITY];
  cell_flag_t         flag   [CAPACITY];
  cell_op_t           cell_op[CAPACITY];
  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] match_hit;
  logic [CAPACITY-1:0] later_hit;

  entry_t  new_entry;
  op_t     op;
  logic    rsp_free;
  logic    rsp_load;
  logic    accept;
  logic    time_ok;
  logic    found;
  logic    full;
  logic    do_insert;
  logic    do_delete;
  logic    do_change;
  logic    list_last;
  status_t status_now;

  // Present the request as an entry; every cell compares against it.
  always_comb begin
    new_entry.name    = req.name_tag;
    new_entry.hour    = req.hour;
    new_entry.minute  = req.minute;
    new_entry.kind    = req.place_kind;
    new_entry.payload = req.payload;
  end

  assign op       = op_t'(req.kind);
  assign rsp_free = !rsp_valid || rsp.ready;
  // Take a request only when idle and the result stage can be refilled.
  assign req.ready = (state == S_IDLE) && rsp_free;
  assign accept    = req.valid && req.ready;

  // Refill the result stage on a single-result request or on each list step.
  assign rsp_load = (accept && !((op == OP_LIST) && (fill_count != '0))) ||
                    ((state == S_LIST) && rsp_free);

  assign time_ok = (req.hour < HOURS_PER_DAY) && (req.minute < MINUTES_PER_HOUR);
  assign found   = |match_hit;
  assign full    = (fill_count == CNT_W'(CAPACITY));

  // Insert checks bad time, then a duplicate key, then fullness.
  assign do_insert = accept && (op == OP_INSERT) && time_ok && !found && !full;
  assign do_delete = accept && (op == OP_DELETE) && found;
  assign do_change = accept && (op == OP_CHANGE) && time_ok && found;

  always_comb begin
    case (op)
      OP_INSERT: begin
        if (!time_ok)  status_now = ST_BAD_TIME;
        else if (found) status_now = ST_PRESENT;
        else if (full)  status_now = ST_FULL;
        else            status_now = ST_DONE;
      end
      OP_DELETE: status_now = found ? ST_DONE : ST_NOT_FOUND;
      OP_CHANGE: begin
        if (!time_ok)   status_now = ST_BAD_TIME;
        else if (found) status_now = ST_DONE;
        else            status_now = ST_NOT_FOUND;
      end
      OP_LIST:   status_now = ST_EMPTY;
      default:   status_now = ST_EMPTY;
    endcase
  end

  // The cell row. Only slots below fill_count take part in comparisons.
  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic before_later;  // an earlier occupied slot already holds a later time
    logic from_match;    // the deleted slot sits at or below this one

    assign occ[j]       = (CNT_W'(j) < fill_count);
    assign match_hit[j] = occ[j] && flag[j].match;
    assign later_hit[j] = occ[j] && flag[j].later;

    if (j == 0) begin : g_first
      assign before_later = 1'b0;
    end else begin : g_rest
      assign before_later = |later_hit[j-1:0];
    end
    assign from_match = |match_hit[j:0];

    always_comb begin
      cell_op[j] = CELL_HOLD;
      if (do_insert) begin
        // Shift down behind the insertion point; drop the new entry in at it.
        if (before_later) begin
          cell_op[j] = CELL_FROM_LO;
        end else if (later_hit[j] || (CNT_W'(j) == fill_count)) begin
          cell_op[j] = CELL_LOAD;
        end
      end else if (do_delete) begin
        // Close the gap: everything from the match upwards moves up one.
        if (from_match && (j < CAPACITY - 1)) begin
          cell_op[j] = CELL_FROM_HI;
        end
      end else if (do_change) begin
        // Retime in place; the order is deliberately left alone.
        if (match_hit[j]) begin
          cell_op[j] = CELL_SET_TIME;
        end
      end
    end

    tskl_cell u_cell (
      .clk       (clk),
      .op        (cell_op[j]),
      .new_entry (new_entry),
      .lo_entry  (slot[(j == 0) ? 0 : j - 1]),
      .hi_entry  (slot[(j == CAPACITY - 1) ? j : j + 1]),
      .entry     (slot[j]),
      .flag      (flag[j])
    );
  end

  assign list_last = ((CNT_W'(list_idx) + CNT_W'(1)) == fill_count);

  // Sequencer, list walk and result stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      list_idx   <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end

      if (do_insert) begin
        fill_count <= fill_count + CNT_W'(1);
      end else if (do_delete) begin
        fill_count <= fill_count - CNT_W'(1);
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            if ((op == OP_LIST) && (fill_count != '0)) begin
              state    <= S_LIST;
              list_idx <= '0;
            end else begin
              rsp_status <= status_now;
              rsp_entry  <= '0;
              rsp_last   <= 1'b1;
            end
          end
        end
        S_LIST: begin
          if (rsp_free) begin
            rsp_status <= ST_ENTRY;
            rsp_entry  <= slot[list_idx];
            rsp_last   <= list_last;
            list_idx   <= list_idx + IDX_W'(1);
            if (list_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.status        = rsp_status;
  assign rsp.entry_name    = rsp_entry.name;
  assign rsp.entry_hour    = rsp_entry.hour;
  assign rsp.entry_minute  = rsp_entry.minute;
  assign rsp.entry_kind    = rsp_entry.kind;
  assign rsp.entry_payload = rsp_entry.payload;
  assign rsp.last          = rsp_last;

  // Occupancy never runs past the row.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(CAPACITY))
    else $error("fill count beyond capacity");

  // Keys stay unique among occupied slots.
  a_key_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match_hit))
    else $error("key held by more than one slot");

  // A successful insert grows the list by exactly one.
  a_insert_grow: assert property (@(posedge clk) disable iff (rst)
    do_insert |=> fill_count == $past(fill_count) + CNT_W'(1))
    else $error("insert did not grow the list");

  // The list walk ends on the final entry and frees the request side.
  a_list_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_LIST) && rsp_free && list_last |=> (state == S_IDLE) && rsp_last)
    else $error("list walk did not finish on the last entry");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import tskl_pkg::*;

  // One reply as it should appear on the response channel.
  typedef struct packed {
    status_t     status;
    logic [63:0] name;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic        kind;
    logic [63:0] payload;
    logic        last;
  } reply_t;

  // Receiver behaviour, chosen anew at random whenever the current mode runs out.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  // Bias of the random traffic: fill the schedule, empty it, or churn it.
  typedef enum logic [1:0] {
    MOOD_GROW,
    MOOD_SHRINK,
    MOOD_CHURN
  } mood_t;

  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = CAPACITY + 8;
  localparam int RANDOM_ITEMS = 420;
  localparam int POOL_SIZE    = 24;

  // Readable keys for the directed part; a string literal packs to the low bytes.
  localparam logic [63:0] KEY_LEMUR = "LEMUR";
  localparam logic [63:0] KEY_OTTER = "OTTER";
  localparam logic [63:0] KEY_HERON = "HERON";
  localparam logic [63:0] KEY_TAPIR = "TAPIR";
  localparam logic [63:0] KEY_ONES  = '1;
  localparam logic [63:0] KEY_ZERO  = '0;
  localparam logic [63:0] PLACE_PEN = "PEN";

  logic clk = 1'b0;
  logic rst = 1'b1;

  tskl_req_if req ();
  tskl_rsp_if rsp ();

  time_sorted_keyed_list uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #5 clk = ~clk;

  // Own copy of the schedule: only slots below sched_fill are ever meaningful.
  entry_t      sched [CAPACITY];
  int          sched_fill;
  reply_t      expected_replies [$];
  logic [63:0] key_pool [POOL_SIZE];

  int failures;
  int replies_checked;
  int peak_fill;
  int full_refusals;
  int sent_by_op [4];
  int burst_left;

  // ---------------------------------------------------------------------------
  // Schedule predictor: update the local copy and queue the replies a request
  // must produce, in order.
  // ---------------------------------------------------------------------------
  function automatic void expect_status(status_t status);
    reply_t r;
    r = '0;
    r.status = status;
    r.last = 1'b1;
    expected_replies.push_back(r);
  endfunction

  function automatic void schedule_update(op_t op, logic [63:0] key, logic [4:0] hour,
                                          logic [5:0] minute, logic place,
                                          logic [63:0] payload);
    int     hit;
    int     slot;
    int     i;
    bit     time_ok;
    entry_t fresh;
    reply_t r;
    hit = -1;
    for (i = 0; i < sched_fill; i++)
      if (hit < 0 && sched[i].name == key) hit = i;
    time_ok = (hour < HOURS_PER_DAY) && (minute < MINUTES_PER_HOUR);
    case (op)
      OP_INSERT: begin
        // Bad time wins over a duplicate key, which wins over a full schedule.
        if (!time_ok) expect_status(ST_BAD_TIME);
        else if (hit >= 0) expect_status(ST_PRESENT);
        else if (sched_fill >= CAPACITY) begin
          expect_status(ST_FULL);
          full_refusals++;
        end else begin
          // Go before the first strictly later entry, so equal times keep arrival order.
          slot = 0;
          while (slot < sched_fill &&
                 !(hour < sched[slot].hour ||
                   (hour == sched[slot].hour && minute < sched[slot].minute)))
            slot++;
          for (i = sched_fill; i > slot; i--) sched[i] = sched[i - 1];
          fresh.name    = key;
          fresh.hour    = hour;
          fresh.minute  = minute;
          fresh.kind    = place;
          fresh.payload = payload;
          sched[slot] = fresh;
          sched_fill++;
          if (sched_fill > peak_fill) peak_fill = sched_fill;
          expect_status(ST_DONE);
        end
      end
      OP_DELETE: begin
        if (hit < 0) expect_status(ST_NOT_FOUND);
        else begin
          for (i = hit; i + 1 < sched_fill; i++) sched[i] = sched[i + 1];
          sched_fill--;
          expect_status(ST_DONE);
        end
      end
      OP_CHANGE: begin
        // Retime in place: the schedule may leave time order afterwards.
        if (!time_ok) expect_status(ST_BAD_TIME);
        else if (hit < 0) expect_status(ST_NOT_FOUND);
        else begin
          sched[hit].hour   = hour;
          sched[hit].minute = minute;
          expect_status(ST_DONE);
        end
      end
      default: begin
        if (sched_fill == 0) expect_status(ST_EMPTY);
        else begin
          for (i = 0; i < sched_fill; i++) begin
            r.status  = ST_ENTRY;
            r.name    = sched[i].name;
            r.hour    = sched[i].hour;
            r.minute  = sched[i].minute;
            r.kind    = sched[i].kind;
            r.payload = sched[i].payload;
            r.last    = (i + 1 == sched_fill);
            expected_replies.push_back(r);
          end
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver. Hold valid between requests of a burst; drop it for a
  // random gap when the burst runs out.
  // ---------------------------------------------------------------------------
  task automatic issue_request(op_t op, logic [63:0] key, logic [4:0] hour,
                               logic [5:0] minute, logic place, logic [63:0] payload);
    int gap;
    req.valid      <= 1'b1;
    req.kind       <= op;
    req.name_tag   <= key;
    req.hour       <= hour;
    req.minute     <= minute;
    req.place_kind <= place;
    req.payload    <= payload;
    do @(posedge clk); while (!req.ready);
    schedule_update(op, key, hour, minute, place, payload);
    sent_by_op[op]++;
    if (burst_left > 0) burst_left--;
    else begin
      gap = $urandom_range(1, 6);
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      // Now and then a long burst with no gaps at all.
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
    end
  endtask

  // Drop valid so nothing is taken twice, then hold until every reply is in.
  task automatic await_all_replies();
    req.valid <= 1'b0;
    wait (expected_replies.size() == 0);
    @(posedge clk);
  endtask

  // Mostly legal times, often clustered to force ties, sometimes out of range.
  task automatic pick_time(output logic [4:0] hour, output logic [5:0] minute);
    int style;
    style = $urandom_range(0, 9);
    if (style == 0) begin
      hour   = 5'($urandom_range(0, 31));
      minute = 6'($urandom_range(0, 63));
    end else if (style < 4) begin
      case ($urandom_range(0, 2))
        0: hour = 5'd0;
        1: hour = 5'd12;
        default: hour = 5'd23;
      endcase
      case ($urandom_range(0, 2))
        0: minute = 6'd0;
        1: minute = 6'd30;
        default: minute = 6'd59;
      endcase
    end else begin
      hour   = 5'($urandom_range(0, 23));
      minute = 6'($urandom_range(0, 59));
    end
  endtask

  // A live key with the given chance, else a pool key, else a stranger.
  function automatic logic [63:0] pick_key(int live_pct);
    if (sched_fill > 0 && $urandom_range(0, 99) < live_pct)
      return sched[$urandom_range(0, sched_fill - 1)].name;
    else if ($urandom_range(0, 9) == 0)
      return {$urandom, $urandom};
    else
      return key_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Listing, deleting and retiming with nothing stored.
  task automatic test_empty_schedule();
    issue_request(OP_LIST,   KEY_LEMUR, 5'd0,  6'd0,  1'b0, '0);
    issue_request(OP_DELETE, KEY_LEMUR, 5'd0,  6'd0,  1'b0, '0);
    issue_request(OP_CHANGE, KEY_LEMUR, 5'd10, 6'd10, 1'b0, '0);
  endtask

  // Out-of-range hours and minutes, on insert and on change, at their edges.
  task automatic test_time_limits();
    issue_request(OP_INSERT, KEY_LEMUR, 5'd24, 6'd0,  1'b0, '0);
    issue_request(OP_INSERT, KEY_LEMUR, 5'd0,  6'd60, 1'b0, '0);
    issue_request(OP_INSERT, KEY_LEMUR, 5'd31, 6'd63, 1'b1, '1);
    issue_request(OP_INSERT, KEY_LEMUR, 5'd23, 6'd59, 1'b1, PLACE_PEN);
    issue_request(OP_CHANGE, KEY_LEMUR, 5'd24, 6'd59, 1'b0, '0);
    issue_request(OP_CHANGE, KEY_LEMUR, 5'd23, 6'd60, 1'b0, '0);
    // Bad time is reported even for a key that is not there.
    issue_request(OP_CHANGE, KEY_OTTER, 5'd31, 6'd0,  1'b0, '0);
  endtask

  // Front and back placement, ties, duplicates and a retime that breaks order.
  task automatic test_ordering();
    issue_request(OP_INSERT, KEY_ONES,  5'd0,  6'd0,  1'b1, '1);
    issue_request(OP_INSERT, KEY_ZERO,  5'd23, 6'd59, 1'b0, {32'hFFFF_FFFF, 32'h0});
    issue_request(OP_INSERT, KEY_OTTER, 5'd23, 6'd59, 1'b0, {32'd7, 32'd3});
    issue_request(OP_INSERT, KEY_HERON, 5'd12, 6'd30, 1'b0, {32'd1, 32'hFFFF_FFFF});
    issue_request(OP_INSERT, KEY_LEMUR, 5'd5,  6'd0,  1'b0, '0);
    issue_request(OP_CHANGE, KEY_HERON, 5'd23, 6'd59, 1'b0, '0);
    // Lands ahead of the retimed entry, which is now strictly later.
    issue_request(OP_INSERT, KEY_TAPIR, 5'd13, 6'd0,  1'b1, PLACE_PEN);
    issue_request(OP_LIST,   KEY_ZERO,  5'd0,  6'd0,  1'b0, '0);
  endtask

  // Close gaps in the middle, at the front and at the back.
  task automatic test_removal();
    issue_request(OP_DELETE, KEY_HERON, 5'd0, 6'd0, 1'b0, '0);
    issue_request(OP_DELETE, KEY_ONES,  5'd0, 6'd0, 1'b0, '0);
    issue_request(OP_DELETE, KEY_OTTER, 5'd0, 6'd0, 1'b0, '0);
    issue_request(OP_DELETE, KEY_OTTER, 5'd0, 6'd0, 1'b0, '0);
    issue_request(OP_LIST,   KEY_ZERO,  5'd0, 6'd0, 1'b0, '0);
    await_all_replies();
  endtask

  // Fill to capacity, probe the refusals at the limit, list, then empty it.
  task automatic test_fill_to_capacity();
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [63:0] key;
    while (sched_fill > 0)
      issue_request(OP_DELETE, sched[$urandom_range(0, sched_fill - 1)].name,
                    5'd0, 6'd0, 1'b0, '0);
    while (sched_fill < CAPACITY) begin
      hour   = 5'($urandom_range(0, 23));
      minute = ($urandom_range(0, 1) == 0) ? 6'd0 : 6'($urandom_range(0, 59));
      issue_request(OP_INSERT, {$urandom, $urandom}, hour, minute, 1'($urandom),
                    {$urandom, $urandom});
    end
    issue_request(OP_INSERT, {$urandom, $urandom}, 5'd1, 6'd1, 1'b0, '0);
    issue_request(OP_INSERT, {$urandom, $urandom}, 5'd30, 6'd1, 1'b0, '0);
    key = sched[$urandom_range(0, CAPACITY - 1)].name;
    issue_request(OP_INSERT, key, 5'd2, 6'd2, 1'b0, '0);
    issue_request(OP_LIST, key, 5'd0, 6'd0, 1'b0, '0);
    while (sched_fill > 0)
      issue_request(OP_DELETE, sched[$urandom_range(0, sched_fill - 1)].name,
                    5'd0, 6'd0, 1'b0, '0);
    issue_request(OP_LIST, key, 5'd0, 6'd0, 1'b0, '0);
  endtask

  // Mixed traffic on a small key pool, with phases that push the fill level
  // up and down so that full, empty and everything between are visited.
  task automatic test_random_traffic();
    int          n;
    int          roll;
    int          insert_cut;
    int          delete_cut;
    int          change_cut;
    mood_t       mood;
    op_t         op;
    logic [63:0] key;
    logic [4:0]  hour;
    logic [5:0]  minute;
    for (n = 0; n < POOL_SIZE; n++) key_pool[n] = {$urandom, $urandom};
    mood = MOOD_GROW;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) mood = mood_t'($urandom_range(0, 2));
      // Pause the sender mid-run until the block has answered everything.
      if (n == RANDOM_ITEMS / 2) await_all_replies();
      case (mood)
        MOOD_GROW: begin
          insert_cut = 60; delete_cut = 72; change_cut = 87;
        end
        MOOD_SHRINK: begin
          insert_cut = 15; delete_cut = 70; change_cut = 87;
        end
        default: begin
          insert_cut = 32; delete_cut = 62; change_cut = 87;
        end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < insert_cut) begin
        op  = OP_INSERT;
        key = pick_key(10);
      end else if (roll < delete_cut) begin
        op  = OP_DELETE;
        key = pick_key(55);
      end else if (roll < change_cut) begin
        op  = OP_CHANGE;
        key = pick_key(55);
      end else begin
        op  = OP_LIST;
        key = {$urandom, $urandom};
      end
      pick_time(hour, minute);
      issue_request(op, key, hour, minute, 1'($urandom), {$urandom, $urandom});
    end
  endtask

  // ---------------------------------------------------------------------------
  // Reply checker: compare every accepted reply with the oldest expectation.
  // ---------------------------------------------------------------------------
  function automatic void compare_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin : check_reply
    reply_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected reply: status %0d, name %0h, last %0b",
                 $time, rsp.status, rsp.entry_name, rsp.last);
        failures++;
      end else begin
        want = expected_replies.pop_front();
        replies_checked++;
        compare_field("status",  64'(want.status),  64'(rsp.status));
        compare_field("name",    want.name,         rsp.entry_name);
        compare_field("hour",    64'(want.hour),    64'(rsp.entry_hour));
        compare_field("minute",  64'(want.minute),  64'(rsp.entry_minute));
        compare_field("kind",    64'(want.kind),    64'(rsp.entry_kind));
        compare_field("payload", want.payload,      rsp.entry_payload);
        compare_field("last",    64'(want.last),    64'(rsp.last));
      end
    end
  end

  // Receiver: switch between no stalls, light, heavy and periodic back-pressure.
  initial begin : reply_backpressure
    stall_mode_t mode;
    int          mode_left;
    rsp.ready <= 1'b0;
    mode      = STALL_NONE;
    mode_left = 0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode      = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 64);
      end
      mode_left--;
      case (mode)
        STALL_NONE:  rsp.ready <= 1'b1;
        STALL_LIGHT: rsp.ready <= ($urandom_range(0, 3) != 0);
        STALL_HEAVY: rsp.ready <= ($urandom_range(0, 3) == 0);
        default:     rsp.ready <= (mode_left % 3 != 0);
      endcase
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  initial begin : stall_watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle = 0;
      else idle++;
    end
    $display("%0t: no handshake for %0d cycles, %0d replies outstanding",
             $time, STALL_LIMIT, expected_replies.size());
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    sched_fill      = 0;
    failures        = 0;
    replies_checked = 0;
    peak_fill       = 0;
    full_refusals   = 0;
    burst_left      = 0;
    foreach (sent_by_op[i]) sent_by_op[i] = 0;
    req.valid      <= 1'b0;
    req.kind       <= OP_INSERT;
    req.name_tag   <= '0;
    req.hour       <= '0;
    req.minute     <= '0;
    req.place_kind <= 1'b0;
    req.payload    <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_empty_schedule();
    test_time_limits();
    test_ordering();
    test_removal();
    test_fill_to_capacity();
    test_random_traffic();

    // Drain, then give a list in flight time to show any stray reply.
    await_all_replies();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_replies.size() != 0) begin
      $display("%0t: %0d expected replies never arrived", $time, expected_replies.size());
      failures++;
    end

    $display("Requests: %0d insert, %0d delete, %0d change, %0d list; %0d replies checked",
             sent_by_op[OP_INSERT], sent_by_op[OP_DELETE], sent_by_op[OP_CHANGE],
             sent_by_op[OP_LIST], replies_checked);
    $display("Peak fill %0d of %0d, %0d inserts refused as full, %0d mismatches",
             peak_fill, CAPACITY, full_refusals, failures);
    if (failures == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
